// ----- rtl/core/sme_pkg.sv -----
package sme_pkg;

  // Widths of the item and result fields.
  localparam int CMD_W    = 2;
  localparam int PERSON_W = 3;

  // At most this many results leave one run.
  localparam int MAX_RESULTS = 8;

  localparam logic [CMD_W-1:0] CMD_LOAD_MAN   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_WOMAN = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RUN        = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [PERSON_W-1:0] person;
    logic [PERSON_W-1:0] position;
    logic [PERSON_W-1:0] choice;
  } item_t;

  typedef struct packed {
    logic [PERSON_W-1:0] woman;
    logic [PERSON_W-1:0] partner;
    logic                last;
  } result_t;

  // Program steps of the sequencer.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PICK,
    ST_PROP,
    ST_RANK_A,
    ST_RANK_B,
    ST_EMIT
  } step_t;

  // Jump conditions.
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_RUN,
    COND_NONE_FREE,
    COND_SETTLED,
    COND_LAST_SENT
  } cond_t;

  typedef struct packed {
    logic  take_in;
    logic  hold;
    cond_t cond;
    step_t target;
    logic  pick;
    logic  propose;
    logic  rank_a;
    logic  rank_b;
    logic  emit;
  } ctrl_t;

  // The control store. A taken condition jumps to target; otherwise the step
  // either holds or falls through to the next one.
  function automatic ctrl_t ucode(step_t s);
    ctrl_t cw;
    cw = '{take_in: 1'b0, hold: 1'b0, cond: COND_NEVER, target: ST_IDLE,
           pick: 1'b0, propose: 1'b0, rank_a: 1'b0, rank_b: 1'b0, emit: 1'b0};
    unique case (s)
      ST_IDLE: begin
        cw.take_in = 1'b1;
        cw.hold    = 1'b1;
        cw.cond    = COND_RUN;
        cw.target  = ST_PICK;
      end
      ST_PICK: begin
        cw.pick   = 1'b1;
        cw.cond   = COND_NONE_FREE;
        cw.target = ST_EMIT;
      end
      ST_PROP: begin
        cw.propose = 1'b1;
        cw.cond    = COND_SETTLED;
        cw.target  = ST_PICK;
      end
      ST_RANK_A: begin
        cw.rank_a = 1'b1;
      end
      ST_RANK_B: begin
        cw.rank_b = 1'b1;
        cw.cond   = COND_ALWAYS;
        cw.target = ST_PICK;
      end
      ST_EMIT: begin
        cw.emit   = 1'b1;
        cw.hold   = 1'b1;
        cw.cond   = COND_LAST_SENT;
        cw.target = ST_IDLE;
      end
      default: begin
        cw.cond   = COND_ALWAYS;
        cw.target = ST_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

// ----- rtl/core/sme_ram.sv -----
module sme_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/stable_matching_engine_unit.sv -----
// Load items give no result; a new item may follow every cycle while the unit is idle.
// A run makes at most PEOPLE*PEOPLE proposals, each through a pick and a propose step,
// plus the rank steps when an engaged woman compares ranks (each preference RAM has a
// single read port); a last pick step finds that no man can propose. Then min(PEOPLE, 8)
// results leave one per cycle unless the output stalls; no item is taken until the last.
// Reset (synchronous) empties the output register and clears the match state;
// the preference RAMs are not cleared and hold nothing valid until written.
module stable_matching_engine_unit import sme_pkg::*; #(
  parameter int PEOPLE = 8
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int IDX_W   = $clog2(PEOPLE);
  localparam int DEPTH   = PEOPLE * PEOPLE;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int NUM_OUT = (PEOPLE < MAX_RESULTS) ? PEOPLE : MAX_RESULTS;
  localparam int OUT_W   = $clog2(NUM_OUT);

  step_t step, step_next;
  ctrl_t cw;
  logic  cond_hit;

  logic item_accept, run_start;

  logic                man_we, rank_we;
  logic [ADDR_W-1:0]   man_waddr, rank_waddr, man_raddr, rank_raddr;
  logic [PERSON_W-1:0] man_rdata, rank_rdata;

  logic [PEOPLE-1:0] free, exhausted, eligible, partner_valid;
  logic [IDX_W-1:0]  next_pos [PEOPLE];
  logic [IDX_W-1:0]  partner [PEOPLE];

  logic [IDX_W-1:0]    pick_idx, pick_pos;
  logic                any_eligible;
  logic [IDX_W-1:0]    m_reg, pos_reg, w_reg, cur_reg;
  logic [PERSON_W-1:0] rank_new;

  logic             w_ok, settled, rd_valid, swap;
  logic [IDX_W-1:0] w_idx, rd_idx, rd_man;

  logic [OUT_W-1:0] emit_idx;
  logic             emit_load, emit_last;

  assign cw          = ucode(step);
  assign item_stall  = !cw.take_in;
  assign item_accept = item_valid && !item_stall;
  assign run_start   = item_accept && (item.cmd == CMD_RUN);

  // Preference stores: rows of PEOPLE entries, one row per man or woman.
  assign man_we = item_accept && (item.cmd == CMD_LOAD_MAN)
                  && (item.person < PEOPLE) && (item.position < PEOPLE);
  assign man_waddr = ADDR_W'(int'(item.person) * PEOPLE + int'(item.position));

  assign rank_we = item_accept && (item.cmd == CMD_LOAD_WOMAN)
                   && (item.person < PEOPLE) && (item.position < PEOPLE)
                   && (item.choice < PEOPLE);
  assign rank_waddr = ADDR_W'(int'(item.person) * PEOPLE + int'(item.choice));

  sme_ram #(.WIDTH(PERSON_W), .DEPTH(DEPTH)) u_man_lists (
    .clk   (clk),
    .we    (man_we),
    .waddr (man_waddr),
    .wdata (item.choice),
    .raddr (man_raddr),
    .rdata (man_rdata)
  );

  sme_ram #(.WIDTH(PERSON_W), .DEPTH(DEPTH)) u_woman_rank (
    .clk   (clk),
    .we    (rank_we),
    .waddr (rank_waddr),
    .wdata (item.position),
    .raddr (rank_raddr),
    .rdata (rank_rdata)
  );

  // Lowest-numbered free man who still has a woman left to try.
  assign eligible     = free & ~exhausted;
  assign any_eligible = |eligible;

  always_comb begin
    pick_idx = '0;
    for (int k = PEOPLE - 1; k >= 0; k--) begin
      if (eligible[k]) begin
        pick_idx = IDX_W'(k);
      end
    end
  end

  assign pick_pos  = next_pos[pick_idx];
  assign man_raddr = ADDR_W'(int'(pick_idx) * PEOPLE + int'(pick_pos));

  // During a proposal the RAM output is the woman he proposes to.
  assign w_ok     = man_rdata < PEOPLE;
  assign w_idx    = IDX_W'(man_rdata);
  assign rd_idx   = cw.emit ? IDX_W'(emit_idx) : w_idx;
  assign rd_valid = partner_valid[rd_idx];
  assign rd_man   = partner[rd_idx];
  assign settled  = !w_ok || !rd_valid;

  // First her rank of the suitor, then her rank of the current partner.
  assign rank_raddr = cw.rank_a ? ADDR_W'(int'(w_reg) * PEOPLE + int'(cur_reg))
                                : ADDR_W'(int'(w_idx) * PEOPLE + int'(m_reg));
  assign swap = cw.rank_b && (rank_new < rank_rdata);

  assign emit_load = cw.emit && (!result_valid || !result_stall);
  assign emit_last = emit_idx == OUT_W'(NUM_OUT - 1);

  always_comb begin
    unique case (cw.cond)
      COND_NEVER:     cond_hit = 1'b0;
      COND_ALWAYS:    cond_hit = 1'b1;
      COND_RUN:       cond_hit = run_start;
      COND_NONE_FREE: cond_hit = !any_eligible;
      COND_SETTLED:   cond_hit = settled;
      COND_LAST_SENT: cond_hit = emit_load && emit_last;
      default:        cond_hit = 1'b0;
    endcase
    if (cond_hit) begin
      step_next = cw.target;
    end else if (cw.hold) begin
      step_next = step;
    end else begin
      step_next = step_t'(step + 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // Match state.
  always_ff @(posedge clk) begin
    if (rst) begin
      partner_valid <= '0;
      free          <= '1;
      exhausted     <= '0;
      emit_idx      <= '0;
      result_valid  <= 1'b0;
      for (int k = 0; k < PEOPLE; k++) begin
        next_pos[k] <= '0;
      end
    end else begin
      if (run_start) begin
        partner_valid <= '0;
        free          <= '1;
        exhausted     <= '0;
        emit_idx      <= '0;
        for (int k = 0; k < PEOPLE; k++) begin
          next_pos[k] <= '0;
        end
      end
      if (cw.propose) begin
        next_pos[m_reg] <= pos_reg + IDX_W'(1);
        if (pos_reg == IDX_W'(PEOPLE - 1)) begin
          exhausted[m_reg] <= 1'b1;
        end
        if (w_ok && !rd_valid) begin
          partner_valid[w_idx] <= 1'b1;
          free[m_reg]          <= 1'b0;
        end
      end
      if (swap) begin
        free[m_reg]   <= 1'b0;
        free[cur_reg] <= 1'b1;
      end
      if (emit_load) begin
        emit_idx     <= emit_idx + OUT_W'(1);
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (cw.pick) begin
      m_reg   <= pick_idx;
      pos_reg <= pick_pos;
    end
    if (cw.propose) begin
      w_reg   <= w_idx;
      cur_reg <= rd_man;
      if (w_ok && !rd_valid) begin
        partner[w_idx] <= m_reg;
      end
    end
    if (cw.rank_a) begin
      rank_new <= rank_rdata;
    end
    if (swap) begin
      partner[w_reg] <= m_reg;
    end
    if (emit_load) begin
      result.woman   <= PERSON_W'(emit_idx);
      result.partner <= rd_valid ? PERSON_W'(rd_man) : '0;
      result.last    <= emit_last;
    end
  end

  // Every engaged woman holds exactly one man who is not free.
  assert property (@(posedge clk) disable iff (rst)
    $countones(partner_valid) + $countones(free) == PEOPLE)
    else $error("engaged women and taken men disagree");

  // A proposing man was free and had women left when he was picked.
  assert property (@(posedge clk) disable iff (rst)
    (step == ST_PROP) |-> (free[m_reg] && !exhausted[m_reg]) && !$past(rst))
    else $error("proposal from a man who could not propose");

  // A rank comparison only happens for a woman who is engaged.
  assert property (@(posedge clk) disable iff (rst)
    (step == ST_RANK_B) |-> partner_valid[w_reg])
    else $error("rank compare for a free woman");

  // Results are only loaded while emitting.
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(step == ST_EMIT))
    else $error("result raised outside the emit step");

  // Loading the last result returns the sequencer to idle.
  assert property (@(posedge clk) disable iff (rst)
    (emit_load && emit_last) |=> (step == ST_IDLE))
    else $error("sequencer did not return to idle after the last result");

endmodule

// ----- tb/match_checker.sv -----
module match_checker import sme_pkg::*; #(
  parameter int PEOPLE = 8
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  logic    item_stall,
  input  item_t   item,
  input  logic    result_valid,
  input  logic    result_stall,
  input  result_t result,
  output int      errors,
  output int      pending,
  output int      runs,
  output int      checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESULTS_PER_RUN = (PEOPLE < MAX_RESULTS) ? PEOPLE : MAX_RESULTS;

  logic [PERSON_W-1:0] man_pref   [PEOPLE][PEOPLE];
  logic [PERSON_W-1:0] woman_rank [PEOPLE][PEOPLE];
  result_t partners_due[$];

  int err_count = 0;
  int run_count = 0;
  int check_count = 0;

  assign errors  = err_count;
  assign runs    = run_count;
  assign checked = check_count;
  assign pending = partners_due.size();

  // Man-proposing stable matching from a clean match state, then one entry per woman.
  task automatic solve_matching();
    bit      engaged  [PEOPLE];
    int      husband  [PEOPLE];
    bit      free_man [PEOPLE];
    int      next_pos [PEOPLE];
    int      m;
    int      w;
    int      cur;
    result_t r;
    for (int i = 0; i < PEOPLE; i++) begin
      engaged[i]  = 1'b0;
      husband[i]  = 0;
      free_man[i] = 1'b1;
      next_pos[i] = 0;
    end
    while (1) begin
      m = 0;
      while (m < PEOPLE && !(free_man[m] && next_pos[m] < PEOPLE)) m++;
      if (m == PEOPLE) break;
      w = man_pref[m][next_pos[m]];
      next_pos[m]++;
      if (w >= PEOPLE) continue;
      if (!engaged[w]) begin
        engaged[w]  = 1'b1;
        husband[w]  = m;
        free_man[m] = 1'b0;
      end else begin
        cur = husband[w];
        // A tie leaves the woman with the man she already has.
        if (woman_rank[w][m] < woman_rank[w][cur]) begin
          husband[w]    = m;
          free_man[m]   = 1'b0;
          free_man[cur] = 1'b1;
        end
      end
    end
    for (int i = 0; i < RESULTS_PER_RUN; i++) begin
      r.woman   = PERSON_W'(i);
      r.partner = engaged[i] ? PERSON_W'(husband[i]) : '0;
      r.last    = (i == RESULTS_PER_RUN - 1);
      partners_due.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (item_valid && !item_stall) begin
        case (item.cmd)
          CMD_LOAD_MAN: begin
            if (item.person < PEOPLE && item.position < PEOPLE)
              man_pref[item.person][item.position] = item.choice;
          end
          CMD_LOAD_WOMAN: begin
            if (item.person < PEOPLE && item.position < PEOPLE && item.choice < PEOPLE)
              woman_rank[item.person][item.choice] = item.position;
          end
          CMD_RUN: begin
            run_count++;
            solve_matching();
          end
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        if (partners_due.size() == 0) begin
          err_count++;
          $display("%0t: result with nothing expected: woman %0d partner %0d last %0d",
                   $time, result.woman, result.partner, result.last);
        end else begin
          want = partners_due.pop_front();
          check_count++;
          if (result.woman !== want.woman) begin
            err_count++;
            $display("%0t: woman expected %0d actual %0d", $time, want.woman, result.woman);
          end
          if (result.partner !== want.partner) begin
            err_count++;
            $display("%0t: partner of woman %0d expected %0d actual %0d",
                     $time, want.woman, want.partner, result.partner);
          end
          if (result.last !== want.last) begin
            err_count++;
            $display("%0t: last flag of woman %0d expected %0d actual %0d",
                     $time, want.woman, want.last, result.last);
          end
        end
      end
    end
  end

endmodule

// ----- tb/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sme_pkg::*;

  localparam int PEOPLE     = 8;
  localparam int ITEMS      = 420;
  localparam int HOLD_LEN   = 400;
  localparam int QUIET_MAX  = 4000;
  localparam int TAIL_LEN   = 300;
  localparam int ITEM_W     = $bits(item_t);
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  int errors;
  int pending;
  int runs;
  int checked;

  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_req  = 0;
  int hold_done = 0;
  int hold_left = 0;
  int quiet     = 0;
  int sent      = 0;
  int loads     = 0;

  logic [PERSON_W-1:0] perm [PEOPLE];

  always #4 clk = ~clk;

  stable_matching_engine_unit #(.PEOPLE(PEOPLE)) dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  match_checker #(.PEOPLE(PEOPLE)) chk (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .errors(errors), .pending(pending), .runs(runs), .checked(checked)
  );

  // The receiver; a requested hold-off is timed here so the sender keeps offering meanwhile.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else if (hold_done != hold_req) begin
      hold_done    <= hold_req;
      hold_left    <= HOLD_LEN;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_MAX) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_MAX);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic item_t mk(logic [CMD_W-1:0] cmd, int who, int pos, int pick);
    item_t x;
    x.cmd      = cmd;
    x.person   = PERSON_W'(who);
    x.position = PERSON_W'(pos);
    x.choice   = PERSON_W'(pick);
    return x;
  endfunction

  // Entered and left at a falling edge.
  task automatic send(item_t x);
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      item       <= item_t'(ITEM_W'($urandom));
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= x;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (x.cmd != CMD_NOP) sent++;
    if (x.cmd == CMD_LOAD_MAN || x.cmd == CMD_LOAD_WOMAN) loads++;
    @(negedge clk);
  endtask

  task automatic shuffle_perm();
    int j;
    logic [PERSON_W-1:0] t;
    for (int i = 0; i < PEOPLE; i++) perm[i] = PERSON_W'(i);
    for (int i = PEOPLE - 1; i > 0; i--) begin
      j       = $urandom_range(i);
      t       = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
  endtask

  // Writes the first n positions of one list from a fresh permutation.
  task automatic load_list(logic [CMD_W-1:0] cmd, int who, int n);
    shuffle_perm();
    for (int p = 0; p < n; p++) send(mk(cmd, who, p, perm[p]));
  endtask

  initial begin
    int phase;
    int cur_phase;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Every list is filled before the first run so no unwritten entry is ever read.
    for (int p = 0; p < PEOPLE; p++) begin
      load_list(CMD_LOAD_MAN, p, PEOPLE);
      load_list(CMD_LOAD_WOMAN, p, PEOPLE);
    end

    send(mk(CMD_NOP, 7, 7, 7));
    send(mk(CMD_RUN, 0, 0, 0));
    send(mk(CMD_LOAD_MAN, 7, 7, 7));
    send(mk(CMD_LOAD_MAN, 0, 0, 0));
    send(mk(CMD_LOAD_WOMAN, 7, 7, 7));
    send(mk(CMD_LOAD_WOMAN, 0, 0, 0));
    send(mk(CMD_RUN, 7, 7, 7));
    // Men 0 and 1 both want woman 0 first and she ranks them equally.
    send(mk(CMD_LOAD_MAN, 1, 0, 0));
    send(mk(CMD_LOAD_WOMAN, 0, 0, 1));
    send(mk(CMD_RUN, 0, 0, 0));
    // Man 1 names only woman 0, so he is turned down until his list runs out
    // and some woman is left without a partner.
    for (int p = 1; p < PEOPLE; p++) send(mk(CMD_LOAD_MAN, 1, p, 0));
    send(mk(CMD_RUN, 0, 0, 0));

    cur_phase = 0;
    while (sent < ITEMS) begin
      phase = (sent * 4) / ITEMS;
      if (phase > 3) phase = 3;
      if (phase != cur_phase) begin
        cur_phase = phase;
        idle_pct  = (phase == 1) ? 46 : (phase == 3) ? 31 : 0;
        stall_pct = (phase == 2) ? 46 : (phase == 3) ? 31 : 0;
        if (phase == 2) begin
          hold_req++;
          send(mk(CMD_RUN, 0, 0, 0));
          for (int k = 0; k < 6; k++)
            send(mk(CMD_LOAD_MAN, $urandom_range(7), $urandom_range(7), $urandom_range(7)));
        end
      end
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin
          load_list(CMD_LOAD_MAN, $urandom_range(PEOPLE - 1), PEOPLE);
          send(mk(CMD_RUN, $urandom_range(7), $urandom_range(7), $urandom_range(7)));
        end
        5, 6: begin
          load_list(CMD_LOAD_WOMAN, $urandom_range(PEOPLE - 1), PEOPLE);
          send(mk(CMD_RUN, $urandom_range(7), $urandom_range(7), $urandom_range(7)));
        end
        7: begin
          repeat ($urandom_range(6, 1)) send(item_t'(ITEM_W'($urandom)));
        end
        8: send(mk(CMD_RUN, $urandom_range(7), $urandom_range(7), $urandom_range(7)));
        default: begin
          // A partly rewritten list leaves repeats, so ties and exhausted men turn up.
          load_list($urandom_range(1) ? CMD_LOAD_MAN : CMD_LOAD_WOMAN,
                    $urandom_range(PEOPLE - 1), $urandom_range(PEOPLE - 1, 1));
          send(mk(CMD_RUN, $urandom_range(7), $urandom_range(7), $urandom_range(7)));
        end
      endcase
    end
    item_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (TAIL_LEN) @(posedge clk);

    $display("Covered %0d preference loads and %0d matching runs, %0d partner results checked.",
             loads, runs, checked);
    $display("Idle phases: none, sender only, receiver only, both; one long receiver hold-off.");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
